// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; ASSERT_OFF removes them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// implication: antecedent implies consequent through |=>, so pass no implication operator inside
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/prw_pkg.sv =====
// ---------------------------------------------------------------------------
// Packet reorder window package
// Shared constants, register codes and state type of the reorder unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prw_pkg;

  localparam int unsigned DefWindow = 32;

  localparam int unsigned IdW     = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLocalId = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPeerId  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFileId  = 2'd2;

  // result kinds
  localparam logic KindAck     = 1'b0;
  localparam logic KindDeliver = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DELIVER
  } state_e;

endpackage

`default_nettype wire

// ===== sv/packet_reorder_window_unit.sv =====
// ---------------------------------------------------------------------------
// Packet reorder window unit
// Receiver-side reorder buffer: acks each packet, stores out-of-order ones
// in a slot memory and flushes a gapless run in sequence order.
// ---------------------------------------------------------------------------
// Usage:
//  - Input words (seq_id, payload_handle, payload_size) are taken when
//    in_valid_i is high and in_stall_o is low. Result words leave on
//    out_valid_o / out_stall_i; every word is first acknowledged, and a word
//    that completes a gapless run is followed by one delivery per stored slot.
//  - Config writes (cfg_index_i, cfg_data_i) are taken whenever cfg_valid_i
//    is high; cfg_ready_o is always high. Write only while the unit is idle.
//  - Order: the acknowledgment sits in the output register in the cycle after
//    the input word is taken. Deliveries follow through states S_READ and
//    S_DELIVER, then come one per cycle while the receiver does not stall.
//  - Throughput: a word that causes no flush leaves the unit ready for the
//    next one; a word that flushes n slots (at most WINDOW) holds off input
//    while the single registered read port walks the run one slot a cycle.
//  - Reset clears the delivered id, byte count, slot valid bits and config
//    registers at once; no clearing pass is needed.
//  - While the receiver stalls, the output register holds its word and the
//    unit stops both taking input and walking the flush.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module packet_reorder_window_unit #(
  parameter int unsigned WINDOW = prw_pkg::DefWindow
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [prw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [prw_pkg::CfgW-1:0]     cfg_data_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [prw_pkg::IdW-1:0]      seq_id_i,
  input  wire logic [prw_pkg::HandleW-1:0]  payload_handle_i,
  input  wire logic [prw_pkg::SizeW-1:0]    payload_size_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              kind_o,
  output logic [prw_pkg::IdW-1:0]           out_seq_id_o,
  output logic [prw_pkg::HandleW-1:0]       out_handle_o,
  output logic [prw_pkg::SizeW-1:0]         out_size_o,
  output logic [prw_pkg::CfgW-1:0]          ack_local_o,
  output logic [prw_pkg::CfgW-1:0]          ack_peer_o,
  output logic [prw_pkg::CfgW-1:0]          ack_file_o,
  output logic                              window_overflow_o,
  output logic [prw_pkg::IdW-1:0]           total_bytes_o,
  output logic                              last_o
);

  import prw_pkg::*;

  localparam int unsigned OW    = $clog2(WINDOW);
  localparam int unsigned CW    = $clog2(WINDOW + 1);
  localparam int unsigned Depth = 1 << OW;
  localparam int unsigned MemW  = HandleW + SizeW;

  // config registers
  logic [CfgW-1:0] local_q, peer_q, file_q;

  // control state
  state_e              state_q, state_d;
  logic [IdW-1:0]      delivered_q, delivered_d;
  logic [IdW-1:0]      bytes_q, bytes_d;
  logic [WINDOW-1:0]   valid_q, valid_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       walk_q, walk_d;
  logic [CW-1:0]       flen_q, flen_d;

  // slot memory: {handle, size}; the id is implied by the slot position
  logic [MemW-1:0]     mem_q [Depth];
  logic [MemW-1:0]     rd_q;
  logic [OW-1:0]       rd_addr;

  // output register
  logic                ov_q, ov_d;
  logic                ld_out;
  logic                kind_q, kind_d;
  logic [IdW-1:0]      oseq_q, oseq_d;
  logic [HandleW-1:0]  ohdl_q, ohdl_d;
  logic [SizeW-1:0]    osize_q, osize_d;
  logic [CfgW-1:0]     olocal_q, olocal_d, opeer_q, opeer_d, ofile_q, ofile_d;
  logic                oovf_q, oovf_d;
  logic [IdW-1:0]      ototal_q, ototal_d;
  logic                olast_q, olast_d;

  // insert path
  logic                out_free, in_acc;
  logic                newer, beyond, ins, ins_new, gapless;
  logic [IdW-1:0]      off_full;
  logic [OW-1:0]       off;
  logic [WINDOW-1:0]   valid_n, prefix;
  logic [CW-1:0]       count_n, walk_inc;
  logic [IdW-1:0]      bytes_inc;
  logic                walk_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '0;
      peer_q  <= '0;
      file_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLocalId: local_q <= cfg_data_i;
        RegPeerId:  peer_q  <= cfg_data_i;
        RegFileId:  file_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign newer    = seq_id_i > delivered_q;
  assign off_full = seq_id_i - delivered_q - 1'b1;
  assign beyond   = newer && (off_full >= IdW'(WINDOW));
  assign ins      = newer && !beyond;
  assign off      = off_full[OW-1:0];
  assign ins_new  = ins && !valid_q[off];

  always_comb begin
    valid_n = valid_q;
    if (ins_new) valid_n[off] = 1'b1;
  end

  assign count_n = count_q + CW'(ins_new);

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      prefix[i] = (CW'(i) < count_n);
    end
  end

  // valid slots must be exactly the first count_n positions
  assign gapless   = ins && (count_n != '0) && (valid_n == prefix);

  assign walk_inc  = walk_q + 1'b1;
  assign walk_last = (walk_inc == flen_q);
  assign bytes_inc = bytes_q + IdW'(rd_q[SizeW-1:0]);

  always_comb begin
    state_d     = state_q;
    delivered_d = delivered_q;
    bytes_d     = bytes_q;
    valid_d     = valid_q;
    count_d     = count_q;
    walk_d      = walk_q;
    flen_d      = flen_q;
    ld_out      = 1'b0;
    rd_addr     = walk_q[OW-1:0];
    kind_d      = kind_q;
    oseq_d      = oseq_q;
    ohdl_d      = ohdl_q;
    osize_d     = osize_q;
    olocal_d    = olocal_q;
    opeer_d     = opeer_q;
    ofile_d     = ofile_q;
    oovf_d      = oovf_q;
    ototal_d    = ototal_q;
    olast_d     = olast_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ld_out   = 1'b1;
          kind_d   = KindAck;
          oseq_d   = seq_id_i;
          ohdl_d   = '0;
          osize_d  = payload_size_i;
          olocal_d = local_q;
          opeer_d  = peer_q;
          ofile_d  = file_q;
          oovf_d   = beyond;
          ototal_d = bytes_q;
          olast_d  = !gapless;
          if (gapless) begin
            // store empties now; the walk reads only the memory
            valid_d = '0;
            count_d = '0;
            flen_d  = count_n;
            walk_d  = '0;
            state_d = S_READ;
          end else begin
            valid_d = valid_n;
            count_d = count_n;
          end
        end
      end
      // interlock: slot 0 may have been written at the accepting edge
      S_READ: begin
        state_d = S_DELIVER;
      end
      S_DELIVER: begin
        if (out_free) begin
          ld_out      = 1'b1;
          rd_addr     = walk_inc[OW-1:0];
          kind_d      = KindDeliver;
          oseq_d      = delivered_q + 1'b1;
          ohdl_d      = rd_q[MemW-1:SizeW];
          osize_d     = rd_q[SizeW-1:0];
          olocal_d    = '0;
          opeer_d     = '0;
          ofile_d     = '0;
          oovf_d      = 1'b0;
          ototal_d    = bytes_inc;
          olast_d     = walk_last;
          delivered_d = delivered_q + 1'b1;
          bytes_d     = bytes_inc;
          walk_d      = walk_inc;
          if (walk_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (ld_out) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      delivered_q <= '0;
      bytes_q     <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      flen_q      <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      delivered_q <= delivered_d;
      bytes_q     <= bytes_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      flen_q      <= flen_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    oseq_q   <= oseq_d;
    ohdl_q   <= ohdl_d;
    osize_q  <= osize_d;
    olocal_q <= olocal_d;
    opeer_q  <= opeer_d;
    ofile_q  <= ofile_d;
    oovf_q   <= oovf_d;
    ototal_q <= ototal_d;
    olast_q  <= olast_d;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && ins_new) begin
      mem_q[off] <= {payload_handle_i, payload_size_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o       = ov_q;
  assign kind_o            = kind_q;
  assign out_seq_id_o      = oseq_q;
  assign out_handle_o      = ohdl_q;
  assign out_size_o        = osize_q;
  assign ack_local_o       = olocal_q;
  assign ack_peer_o        = opeer_q;
  assign ack_file_o        = ofile_q;
  assign window_overflow_o = oovf_q;
  assign total_bytes_o     = ototal_q;
  assign last_o            = olast_q;

  `ASSERT_ALWAYS(a_count_matches, clk_i, rst_ni, count_q == CW'($countones(valid_q)))
  `ASSERT_ALWAYS(a_store_empty_in_walk, clk_i, rst_ni,
    (state_q == S_IDLE) || (valid_q == '0))
  `ASSERT_IMPL(a_delivery_advances_id, clk_i, rst_ni,
    (state_q == S_DELIVER) && ld_out, delivered_q == $past(delivered_q) + 1'b1)
  `ASSERT_IMPL(a_last_ends_walk, clk_i, rst_ni,
    (state_q == S_DELIVER) && ld_out && walk_last, state_q == S_IDLE && olast_q)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// Reorder window unit testbench
// Sends packet words through packet_reorder_window_unit and checks every
// acknowledgment and delivery word against an in-bench model of the window.
// A short table of directed words comes first. After it come a full-window
// flush and random shuffled sequences under several id settings and
// idle/stall mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import prw_pkg::*;

  localparam int unsigned WinSlots = DefWindow;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [IdW-1:0]     seq_id;
    logic [HandleW-1:0] handle;
    logic [SizeW-1:0]   size;
    logic [CfgW-1:0]    ack_local;
    logic [CfgW-1:0]    ack_peer;
    logic [CfgW-1:0]    ack_file;
    logic               ovf;
    logic [IdW-1:0]     total;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [IdW-1:0]     seq_id;
    logic [HandleW-1:0] handle;
    logic [SizeW-1:0]   size;
    logic               typed;
    logic               ovf;
    logic [IdW-1:0]     total;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [IdW-1:0]     seq_id_i = '0;
  logic [HandleW-1:0] payload_handle_i = '0;
  logic [SizeW-1:0]   payload_size_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               kind_o;
  logic [IdW-1:0]     out_seq_id_o;
  logic [HandleW-1:0] out_handle_o;
  logic [SizeW-1:0]   out_size_o;
  logic [CfgW-1:0]    ack_local_o;
  logic [CfgW-1:0]    ack_peer_o;
  logic [CfgW-1:0]    ack_file_o;
  logic               window_overflow_o;
  logic [IdW-1:0]     total_bytes_o;
  logic               last_o;

  packet_reorder_window_unit #(.WINDOW(WinSlots)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .seq_id_i         (seq_id_i),
    .payload_handle_i (payload_handle_i),
    .payload_size_i   (payload_size_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .out_seq_id_o     (out_seq_id_o),
    .out_handle_o     (out_handle_o),
    .out_size_o       (out_size_o),
    .ack_local_o      (ack_local_o),
    .ack_peer_o       (ack_peer_o),
    .ack_file_o       (ack_file_o),
    .window_overflow_o(window_overflow_o),
    .total_bytes_o    (total_bytes_o),
    .last_o           (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // window model state
  logic [CfgW-1:0]    id_local = '0;
  logic [CfgW-1:0]    id_peer = '0;
  logic [CfgW-1:0]    id_file = '0;
  logic [IdW-1:0]     win_delivered = '0;
  logic [IdW-1:0]     win_total = '0;
  logic               win_valid [WinSlots];
  logic [IdW-1:0]     win_id [WinSlots];
  logic [HandleW-1:0] win_handle [WinSlots];
  logic [SizeW-1:0]   win_size [WinSlots];
  int unsigned        win_count = 0;

  result_t     pending_words[$];
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  initial begin
    foreach (win_valid[k]) win_valid[k] = 1'b0;
  end

  // ack first, then a flush when the stored slots form a prefix of the window
  task automatic window_predict(input logic [IdW-1:0] id, input logic [HandleW-1:0] hdl,
                                input logic [SizeW-1:0] sz, output result_t res[$]);
    int unsigned off;
    bit          run_ok;
    result_t     r;
    res = {};
    r = '0;
    r.kind = KindAck;
    r.seq_id = id;
    r.size = sz;
    r.ack_local = id_local;
    r.ack_peer = id_peer;
    r.ack_file = id_file;
    r.total = win_total;
    r.last = 1'b1;
    if (id <= win_delivered) begin
      res.push_back(r);
      return;
    end
    off = id - win_delivered - 1;
    if (off >= WinSlots) begin
      r.ovf = 1'b1;
      res.push_back(r);
      return;
    end
    if (!win_valid[off]) begin
      win_valid[off] = 1'b1;
      win_id[off] = id;
      win_handle[off] = hdl;
      win_size[off] = sz;
      win_count++;
    end
    run_ok = 1'b1;
    for (int unsigned i = 0; i < win_count; i++) begin
      if (!win_valid[i]) run_ok = 1'b0;
    end
    r.last = !run_ok;
    res.push_back(r);
    if (!run_ok) return;
    for (int unsigned i = 0; i < win_count; i++) begin
      win_total = win_total + win_size[i];
      win_delivered = win_id[i];
      r = '0;
      r.kind = KindDeliver;
      r.seq_id = win_id[i];
      r.handle = win_handle[i];
      r.size = win_size[i];
      r.total = win_total;
      r.last = (i + 1 == win_count);
      res.push_back(r);
    end
    foreach (win_valid[k]) win_valid[k] = 1'b0;
    win_count = 0;
  endtask

  function automatic logic [15:0] rand16();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_packet(input logic [IdW-1:0] id, input logic [HandleW-1:0] hdl,
                             input logic [SizeW-1:0] sz, input bit typed,
                             input result_t typed_ack);
    result_t fresh[$];
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    seq_id_i <= id;
    payload_handle_i <= hdl;
    payload_size_i <= sz;
    do @(posedge clk_i); while (in_stall_o);
    window_predict(id, hdl, sz, fresh);
    if (typed) fresh[0] = typed_ack;
    foreach (fresh[k]) pending_words.push_back(fresh[k]);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegLocalId: id_local = val;
      RegPeerId:  id_peer = val;
      RegFileId:  id_file = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_ids(input logic [CfgW-1:0] loc, input logic [CfgW-1:0] peer,
                         input logic [CfgW-1:0] file);
    cfg_write(RegLocalId, loc);
    cfg_write(RegPeerId, peer);
    cfg_write(RegFileId, file);
    cfg_write(RegUnused, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // lower valid first so the last word is not taken twice while waiting
  task automatic drain(input bit settle);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    if (settle) repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one shuffled run from the next expected id, with noise mixed in
  task automatic send_run(input int unsigned n, input bit broken);
    logic [IdW-1:0] base;
    logic [IdW-1:0] ids[$];
    logic [IdW-1:0] tmp;
    logic [IdW-1:0] noise;
    int unsigned    j;
    base = win_delivered;
    for (int unsigned k = 1; k <= n; k++) ids.push_back(base + k);
    for (int unsigned k = n - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = ids[k];
      ids[k] = ids[j];
      ids[j] = tmp;
    end
    // a missing word leaves the run stored until a later run fills the gap
    if (broken && n > 1) ids.delete($urandom_range(n - 1));
    foreach (ids[k]) begin
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(3))
          0: noise = $urandom_range(win_delivered);
          1: noise = win_delivered + WinSlots + 1 + $urandom_range(4095);
          2: noise = ids[$urandom_range(k)];
          default: noise = $urandom;
        endcase
        send_packet(noise, rand16(), rand16(), 1'b0, '0);
      end
      send_packet(ids[k], rand16(), rand16(), 1'b0, '0);
    end
  endtask

  task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                              input bit long_hold, input bit mid_pause);
    int unsigned start;
    int unsigned n;
    bit          paused;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start = words_sent;
    paused = 1'b0;
    while (words_sent - start < 44) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, WinSlots) : $urandom_range(1, 6);
      send_run(n, $urandom_range(4) == 0);
      if (long_hold && hold_reqs == hold_seen && words_sent - start < 20) hold_reqs++;
      if (mid_pause && !paused && words_sent - start > 25) begin
        drain(1'b0);
        paused = 1'b1;
      end
    end
  endtask

  // receiver: random stall, or a long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic void chk_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, got id %h kind %b",
                 $time, out_seq_id_o, kind_o);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        chk_field("kind", 32'(want.kind), 32'(kind_o));
        chk_field("seq_id", want.seq_id, out_seq_id_o);
        chk_field("handle", 32'(want.handle), 32'(out_handle_o));
        chk_field("size", 32'(want.size), 32'(out_size_o));
        chk_field("ack_local", want.ack_local, ack_local_o);
        chk_field("ack_peer", want.ack_peer, ack_peer_o);
        chk_field("ack_file", want.ack_file, ack_file_o);
        chk_field("overflow", 32'(want.ovf), 32'(window_overflow_o));
        chk_field("total", want.total, total_bytes_o);
        chk_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t       dir_rows [11];
    result_t        typed_ack;
    logic [IdW-1:0] base;

    // typed rows: single ack under reset ids (all zero)
    dir_rows = '{
      '{32'd0,        16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'd0},     // old id at reset
      '{32'hFFFFFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 32'd0},     // far beyond window
      '{32'd33,       16'h1234, 16'h4321, 1'b1, 1'b1, 32'd0},     // one past window
      '{32'd3,        16'h00AA, 16'd100,  1'b1, 1'b0, 32'd0},
      '{32'd3,        16'h00BB, 16'd200,  1'b1, 1'b0, 32'd0},     // duplicate
      '{32'd2,        16'h5555, 16'd0,    1'b1, 1'b0, 32'd0},
      '{32'd1,        16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd0},     // flushes 1..3
      '{32'd3,        16'hAAAA, 16'd1,    1'b1, 1'b0, 32'd65635}, // old, equal to last
      '{32'd4,        16'h0000, 16'd1,    1'b0, 1'b0, 32'd0},     // in order
      '{32'd37,       16'h8000, 16'h8000, 1'b1, 1'b1, 32'd65636},
      '{32'd36,       16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 32'd65636}  // top slot
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      typed_ack = '0;
      typed_ack.kind = KindAck;
      typed_ack.seq_id = dir_rows[k].seq_id;
      typed_ack.size = dir_rows[k].size;
      typed_ack.ovf = dir_rows[k].ovf;
      typed_ack.total = dir_rows[k].total;
      typed_ack.last = 1'b1;
      send_packet(dir_rows[k].seq_id, dir_rows[k].handle, dir_rows[k].size,
                  dir_rows[k].typed, typed_ack);
    end

    // fill the rest of the window top down: the last word flushes all slots
    base = win_delivered;
    for (int unsigned k = WinSlots - 1; k >= 1; k--) begin
      send_packet(base + k, rand16(), rand16(), 1'b0, '0);
    end

    send_packet(win_delivered + 1, rand16(), rand16(), 1'b0, '0);

    drain(1'b1);
    set_ids(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    random_phase(0, 0, 1'b1, 1'b0);

    drain(1'b1);
    set_ids($urandom, $urandom, $urandom);
    random_phase(78, 0, 1'b0, 1'b0);

    drain(1'b1);
    set_ids(32'h0, 32'h0, 32'h0);
    random_phase(0, 78, 1'b0, 1'b1);

    drain(1'b1);
    set_ids($urandom, $urandom, $urandom);
    random_phase(14, 14, 1'b0, 1'b0);

    drain(1'b0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
